@@ rtl/wprf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wprf_pkg: shared types and constants
// Beat structs, protocol numbers and header offsets for the rule filter.
// ----------------------------------------------------------------------------
package wprf_pkg;

  localparam int RULE_COUNT_DEF = 256;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic       DIR_EGRESS = 1'b1;

  localparam logic [15:0] OFS_PROTO    = 16'd23;
  localparam logic [15:0] OFS_SA_FIRST = 16'd26;
  localparam logic [15:0] OFS_SA_LAST  = 16'd29;
  localparam logic [15:0] OFS_DA_FIRST = 16'd30;
  localparam logic [15:0] OFS_DA_LAST  = 16'd33;
  localparam logic [15:0] OFS_PT_FIRST = 16'd34;
  localparam logic [15:0] OFS_PT_LAST  = 16'd37;
  localparam logic [15:0] IP_HDR_END   = 16'd34;
  localparam logic [15:0] TCP_HDR_END  = 16'd54;
  localparam logic [15:0] UDP_HDR_END  = 16'd42;
  localparam logic [15:0] SIZE_MAX     = 16'hFFFF;

  localparam logic FUNC_RULE = 1'b0;

  typedef struct packed {
    logic        func;
    logic [7:0]  rule_index;
    logic        rule_enable;
    logic [31:0] rule_src_addr;
    logic [15:0] rule_src_port;
    logic [15:0] rule_dst_port;
    logic [7:0]  rule_proto;
    logic        rule_dir;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic        frame_dir;
  } in_beat_t;

  typedef struct packed {
    logic        drop;
    logic        headers_ok;
    logic        matched;
    logic [7:0]  match_index;
    logic        out_dir;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  proto;
    logic [15:0] frame_size;
  } out_beat_t;

  typedef struct packed {
    logic rule_wr;
    logic byte_in;
    logic scan_start;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic headers_ok;
    logic hit;
    logic scan_last;
  } status_t;

endpackage

@@ rtl/wprf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wprf_datapath: rule memory, header parser and rule scan
// Stores rules in memories, parses frame bytes, and steps through the
// table one entry per cycle looking for the lowest matching rule.
// ----------------------------------------------------------------------------
module wprf_datapath #(
  parameter int RULE_COUNT = wprf_pkg::RULE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  wprf_pkg::in_beat_t  in_beat,
  input  wprf_pkg::cmd_t      cmd,
  output wprf_pkg::status_t   status,
  output wprf_pkg::out_beat_t out_beat
);
  import wprf_pkg::*;

  localparam int IW = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam int CW = $clog2(RULE_COUNT + 1);

  logic [RULE_COUNT-1:0] valid;
  logic [31:0] addr_mem  [RULE_COUNT];
  logic [31:0] ports_mem [RULE_COUNT];
  logic [8:0]  pd_mem    [RULE_COUNT];

  logic [15:0] byte_offset;
  logic [31:0] hdr_src_addr, hdr_dst_addr, hdr_ports;
  logic [7:0]  hdr_proto;
  logic        dir;

  logic [31:0] sp_dp;
  logic [CW-1:0] scan_idx;   // address presented to memory
  logic [CW-1:0] rd_idx;     // address of registered read data
  logic        rd_ok;
  logic [31:0] rd_addr, rd_ports;
  logic [8:0]  rd_pd;
  logic        rd_valid;
  logic        hit;
  logic [7:0]  hit_idx;
  logic        entry_hit;
  logic        ports_ok;

  wire [CW-1:0] wr_idx_ext = CW'(in_beat.rule_index);
  wire          wr_in_range = (32'(in_beat.rule_index) < RULE_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.rule_wr && wr_in_range && in_beat.rule_enable) begin
      addr_mem[wr_idx_ext[IW-1:0]]  <= in_beat.rule_src_addr;
      ports_mem[wr_idx_ext[IW-1:0]] <= {in_beat.rule_src_port, in_beat.rule_dst_port};
      pd_mem[wr_idx_ext[IW-1:0]]    <= {in_beat.rule_dir, in_beat.rule_proto};
    end
    rd_addr  <= addr_mem[scan_idx[IW-1:0]];
    rd_ports <= ports_mem[scan_idx[IW-1:0]];
    rd_pd    <= pd_mem[scan_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.rule_wr && wr_in_range) begin
      valid[wr_idx_ext[IW-1:0]] <= in_beat.rule_enable;
    end
  end

  // parser
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      byte_offset  <= '0;
      hdr_src_addr <= '0;
      hdr_dst_addr <= '0;
      hdr_ports    <= '0;
      hdr_proto    <= '0;
    end else if (cmd.byte_in && byte_offset != SIZE_MAX) begin
      if (byte_offset == OFS_PROTO) begin
        hdr_proto <= in_beat.frame_byte;
      end else if (byte_offset >= OFS_SA_FIRST && byte_offset <= OFS_SA_LAST) begin
        hdr_src_addr <= {hdr_src_addr[23:0], in_beat.frame_byte};
      end else if (byte_offset >= OFS_DA_FIRST && byte_offset <= OFS_DA_LAST) begin
        hdr_dst_addr <= {hdr_dst_addr[23:0], in_beat.frame_byte};
      end else if (byte_offset >= OFS_PT_FIRST && byte_offset <= OFS_PT_LAST) begin
        hdr_ports <= {hdr_ports[23:0], in_beat.frame_byte};
      end
      byte_offset <= byte_offset + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_in && in_beat.frame_end) begin
      dir <= in_beat.frame_dir;
    end
  end

  assign ports_ok = (hdr_proto == PROTO_TCP && byte_offset >= TCP_HDR_END) ||
                    (hdr_proto == PROTO_UDP && byte_offset >= UDP_HDR_END);
  assign sp_dp = ports_ok ? hdr_ports : 32'd0;

  assign rd_valid  = valid[rd_idx[IW-1:0]];
  assign entry_hit = rd_ok && rd_valid && rd_pd[8] == dir &&
                     (rd_addr == 32'd0 || rd_addr == hdr_src_addr) &&
                     (rd_ports[31:16] == 16'd0 || rd_ports[31:16] == sp_dp[31:16]) &&
                     (rd_ports[15:0] == 16'd0 || rd_ports[15:0] == sp_dp[15:0]) &&
                     (rd_pd[7:0] == 8'd0 || rd_pd[7:0] == hdr_proto);

  // scan: memory read data is registered, so scan_idx runs ahead of rd_idx
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_idx   <= '0;
      rd_ok    <= 1'b0;
      hit      <= 1'b0;
      hit_idx  <= '0;
    end else if (cmd.scan_start) begin
      scan_idx <= CW'(1);
      rd_idx   <= '0;
      rd_ok    <= 1'b1;
      hit      <= 1'b0;
      hit_idx  <= '0;
    end else if (cmd.scan_step) begin
      if (entry_hit && !hit) begin
        hit     <= 1'b1;
        hit_idx <= 8'(rd_idx);
      end
      rd_idx   <= scan_idx;
      rd_ok    <= (32'(scan_idx) < RULE_COUNT);
      if (cmd.finish) begin
        scan_idx <= '0;
      end else if (32'(scan_idx) < RULE_COUNT) begin
        scan_idx <= scan_idx + CW'(1);
      end
    end
  end

  // scan_idx rests at entry 0 so the read made with scan_start fetches entry 0
  assign status.headers_ok = (byte_offset >= IP_HDR_END);
  assign status.hit        = hit || entry_hit;
  assign status.scan_last  = !rd_ok || (32'(rd_idx) == RULE_COUNT - 1) || hit || entry_hit;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_beat.headers_ok  <= status.headers_ok;
      out_beat.out_dir     <= dir;
      out_beat.frame_size  <= byte_offset;
      if (status.headers_ok) begin
        out_beat.drop        <= hit || entry_hit;
        out_beat.matched     <= hit || entry_hit;
        out_beat.match_index <= hit ? hit_idx : (entry_hit ? 8'(rd_idx) : 8'd0);
        out_beat.src_addr    <= hdr_src_addr;
        out_beat.dst_addr    <= hdr_dst_addr;
        out_beat.src_port    <= sp_dp[31:16];
        out_beat.dst_port    <= sp_dp[15:0];
        out_beat.proto       <= hdr_proto;
      end else begin
        out_beat.drop        <= (dir == DIR_EGRESS);
        out_beat.matched     <= 1'b0;
        out_beat.match_index <= '0;
        out_beat.src_addr    <= '0;
        out_beat.dst_addr    <= '0;
        out_beat.src_port    <= '0;
        out_beat.dst_port    <= '0;
        out_beat.proto       <= '0;
      end
    end
  end

endmodule

@@ rtl/wprf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wprf_ctrl: sequencing state machine
// Accepts beats, launches the rule scan at frame end and issues the result.
// ----------------------------------------------------------------------------
module wprf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  input  logic              frame_end,
  input  wprf_pkg::status_t status,
  output wprf_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);
  import wprf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_SCAN, S_FIN} state_t;
  state_t state;

  wire take = start && !busy;

  always_comb begin
    cmd = '0;
    cmd.rule_wr    = take && func == FUNC_RULE;
    cmd.byte_in    = take && func != FUNC_RULE;
    cmd.scan_start = (state == S_PREP);
    cmd.scan_step  = (state == S_SCAN);
    cmd.finish     = (state == S_FIN) ||
                     (state == S_SCAN && (status.scan_last || !status.headers_ok));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      case (state)
        S_IDLE: begin
          if (cmd.byte_in && frame_end) begin
            state <= S_PREP;
            busy  <= 1'b1;
          end
        end
        S_PREP: state <= S_SCAN;
        S_SCAN: begin
          if (cmd.finish) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/wildcard_packet_rule_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_packet_rule_filter: five-tuple wildcard drop-rule filter
// Rule writes and frame bytes are accepted while busy is low. After the last
// byte of a frame, busy stays high while the rule memory is scanned one entry
// per cycle from index 0, stopping at the first hit, or at once for a frame
// too short for its headers. The result appears with done for one cycle and
// must be taken then; the block cannot be stalled.
// ----------------------------------------------------------------------------
module wildcard_packet_rule_filter #(
  parameter int RULE_COUNT = wprf_pkg::RULE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  wprf_pkg::in_beat_t  in_beat,
  output logic                done,
  output wprf_pkg::out_beat_t out_beat
);
  import wprf_pkg::*;

  cmd_t    cmd;
  status_t status;

  wprf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(in_beat.func),
    .frame_end(in_beat.frame_end), .status(status), .cmd(cmd),
    .busy(busy), .done(done)
  );

  wprf_datapath #(.RULE_COUNT(RULE_COUNT)) u_dp (
    .clk(clk), .rst(rst), .in_beat(in_beat), .cmd(cmd),
    .status(status), .out_beat(out_beat)
  );

endmodule

@@ rtl/wprf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wprf_checker: port-level checks
// Watches the top level ports for result consistency and handshake order.
// ----------------------------------------------------------------------------
module wprf_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input wprf_pkg::in_beat_t  in_beat,
  input logic                done,
  input wprf_pkg::out_beat_t out_beat
);
  import wprf_pkg::*;

  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    start && !busy && in_beat.func != FUNC_RULE && in_beat.frame_end |=> busy)
    else $error("busy not raised after frame end");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held");

  a_drop_rule: assert property (@(posedge clk) disable iff (rst)
    done && out_beat.headers_ok |-> out_beat.drop == out_beat.matched)
    else $error("drop differs from match");

  a_no_match_short: assert property (@(posedge clk) disable iff (rst)
    done && !out_beat.headers_ok |-> !out_beat.matched && out_beat.match_index == 8'd0)
    else $error("match on short frame");

endmodule

bind wildcard_packet_rule_filter wprf_checker u_wprf_checker (.*);

@@ tb/wildcard_packet_rule_filter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_packet_rule_filter_test: self-checking bench for the rule filter
// Drives rule writes and frame bytes through the start/busy handshake,
// predicts each frame verdict from a local copy of the rule table and
// checks every done beat as a whole against the oldest prediction.
// ----------------------------------------------------------------------------
module wildcard_packet_rule_filter_test;
  import wprf_pkg::*;

  localparam int NRULES = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  in_beat_t in_beat = '0;
  out_beat_t out_beat;

  wildcard_packet_rule_filter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_beat(in_beat), .done(done), .out_beat(out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic        tbl_valid [NRULES];
  logic [31:0] tbl_addr [NRULES];
  logic [15:0] tbl_sport [NRULES];
  logic [15:0] tbl_dport [NRULES];
  logic [7:0]  tbl_proto [NRULES];
  logic        tbl_dir [NRULES];
  logic [15:0] pos;
  logic [31:0] p_sa, p_da, p_ports;
  logic [7:0]  p_proto;

  out_beat_t verdict_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  function automatic bit hits(logic [31:0] r, logic [31:0] v);
    return r == 0 || r == v;
  endfunction

  task automatic predict_beat(in_beat_t b);
    out_beat_t o;
    if (b.func == FUNC_RULE) begin
      tbl_valid[b.rule_index] = b.rule_enable;
      if (b.rule_enable) begin
        tbl_addr[b.rule_index] = b.rule_src_addr;
        tbl_sport[b.rule_index] = b.rule_src_port;
        tbl_dport[b.rule_index] = b.rule_dst_port;
        tbl_proto[b.rule_index] = b.rule_proto;
        tbl_dir[b.rule_index] = b.rule_dir;
      end
      return;
    end
    if (pos != SIZE_MAX) begin
      if (pos == OFS_PROTO) p_proto = b.frame_byte;
      else if (pos >= OFS_SA_FIRST && pos <= OFS_SA_LAST) p_sa = {p_sa[23:0], b.frame_byte};
      else if (pos >= OFS_DA_FIRST && pos <= OFS_DA_LAST) p_da = {p_da[23:0], b.frame_byte};
      else if (pos >= OFS_PT_FIRST && pos <= OFS_PT_LAST)
        p_ports = {p_ports[23:0], b.frame_byte};
      pos = pos + 16'd1;
    end
    if (!b.frame_end) return;
    o = '0;
    o.out_dir = b.frame_dir;
    o.frame_size = pos;
    o.headers_ok = pos >= IP_HDR_END;
    if (o.headers_ok) begin
      o.src_addr = p_sa;
      o.dst_addr = p_da;
      o.proto = p_proto;
      if ((p_proto == PROTO_TCP && pos >= TCP_HDR_END) ||
          (p_proto == PROTO_UDP && pos >= UDP_HDR_END)) begin
        o.src_port = p_ports[31:16];
        o.dst_port = p_ports[15:0];
      end
      for (int i = 0; i < NRULES; i++) begin
        if (!o.matched && tbl_valid[i] && tbl_dir[i] == b.frame_dir &&
            hits(tbl_addr[i], p_sa) && hits(tbl_sport[i], o.src_port) &&
            hits(tbl_dport[i], o.dst_port) && hits(tbl_proto[i], p_proto)) begin
          o.matched = 1'b1;
          o.match_index = i[7:0];
        end
      end
      o.drop = o.matched;
    end else begin
      o.drop = b.frame_dir == DIR_EGRESS;
    end
    verdict_q.push_back(o);
    pos = 0; p_sa = 0; p_da = 0; p_ports = 0; p_proto = 0;
  endtask

  // hold start until accepted at a rising edge with busy low
  task automatic send_beat(in_beat_t b, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy);
    predict_beat(b);
    @(negedge clk);
  endtask

  task automatic go_idle();
    start <= 1'b0;
  endtask

  task automatic write_rule(int idx, bit en, logic [31:0] sa, logic [15:0] sp,
                            logic [15:0] dp, logic [7:0] pr, bit dir);
    in_beat_t b;
    b = '0;
    b.func = FUNC_RULE;
    b.rule_index = idx[7:0];
    b.rule_enable = en;
    b.rule_src_addr = sa;
    b.rule_src_port = sp;
    b.rule_dst_port = dp;
    b.rule_proto = pr;
    b.rule_dir = dir;
    b.frame_byte = 8'($urandom);
    send_beat(b);
  endtask

  // frame with a chosen header; bytes outside parsed offsets are random
  task automatic send_frame(int len, bit dir, logic [7:0] pr, logic [31:0] sa,
                            logic [31:0] da, logic [31:0] ports, bit gaps = 1'b1);
    in_beat_t b;
    for (int k = 0; k < len; k++) begin
      b = '0;
      b.func = ~FUNC_RULE;
      b.frame_byte = 8'($urandom);
      if (k == 23) b.frame_byte = pr;
      else if (k >= 26 && k <= 29) b.frame_byte = sa[8*(29-k) +: 8];
      else if (k >= 30 && k <= 33) b.frame_byte = da[8*(33-k) +: 8];
      else if (k >= 34 && k <= 37) b.frame_byte = ports[8*(37-k) +: 8];
      b.frame_end = k == len - 1;
      b.frame_dir = (k == len - 1) ? dir : 1'($urandom_range(0, 1));
      // random rule traffic between frame bytes, disabling rule 255
      if (gaps && $urandom_range(0, 30) == 0)
        write_rule(255, 1'b0, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
                   1'($urandom));
      send_beat(b, gaps);
    end
  endtask

  always @(posedge clk) begin
    out_beat_t exp_o;
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_beat);
        errors++;
      end else begin
        exp_o = verdict_q.pop_front();
        if (out_beat !== exp_o) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_o, out_beat);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL wildcard_packet_rule_filter");
      $finish;
    end
  end

  function automatic logic [31:0] pick_addr(logic [31:0] a);
    return ($urandom_range(0, 1)) ? a : $urandom;
  endfunction

  task automatic test_truncated();
    send_frame(1, 1'b0, 0, 0, 0, 0);
    send_frame(1, 1'b1, 0, 0, 0, 0);
    send_frame(33, 1'b0, PROTO_TCP, 32'hFFFF_FFFF, 1, 2);
    send_frame(33, 1'b1, PROTO_UDP, 32'hFFFF_FFFF, 1, 2);
  endtask

  task automatic test_wildcards();
    write_rule(0, 1'b1, 32'h0A00_0001, 0, 0, 0, 1'b0);
    write_rule(5, 1'b1, 0, 16'hFFFF, 16'h0050, PROTO_TCP, 1'b0);
    write_rule(255, 1'b1, 0, 0, 0, 0, 1'b1);
    send_frame(34, 1'b0, PROTO_TCP, 32'h0A00_0001, 32'hFFFF_FFFF, 0);
    send_frame(54, 1'b0, PROTO_TCP, 32'h0B00_0001, 0, 32'hFFFF_0050);
    send_frame(53, 1'b0, PROTO_TCP, 32'h0B00_0001, 0, 32'hFFFF_0050);
    send_frame(42, 1'b0, PROTO_UDP, 32'h0B00_0001, 0, 32'h1234_5678);
    send_frame(41, 1'b1, PROTO_UDP, 0, 0, 32'h1234_5678);
    send_frame(40, 1'b1, 8'hFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    write_rule(255, 1'b0, 0, 0, 0, 0, 1'b1);
    send_frame(40, 1'b1, 8'hFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    write_rule(0, 1'b0, 0, 0, 0, 0, 1'b0);
    write_rule(5, 1'b0, 0, 0, 0, 0, 1'b0);
  endtask

  task automatic test_random();
    logic [31:0] addrs [4];
    logic [31:0] prts [4];
    logic [7:0] pr;
    int len;
    foreach (addrs[i]) begin
      addrs[i] = $urandom;
      prts[i] = $urandom;
    end
    for (int n = 0; n < 15; n++) begin
      if ($urandom_range(0, 2) == 0) begin
        write_rule($urandom_range(0, 255), $urandom_range(0, 3) != 0,
                   $urandom_range(0, 2) ? addrs[$urandom_range(0, 3)] : 0,
                   $urandom_range(0, 1) ? prts[$urandom_range(0, 3)][31:16] : 0,
                   $urandom_range(0, 1) ? prts[$urandom_range(0, 3)][15:0] : 0,
                   $urandom_range(0, 1) ? ($urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP)
                                        : ($urandom_range(0, 3) ? 8'd0 : 8'($urandom)),
                   1'($urandom_range(0, 1)));
      end
      case ($urandom_range(0, 5))
        0: pr = PROTO_TCP;
        1: pr = PROTO_UDP;
        2: pr = 8'($urandom);
        default: pr = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
      endcase
      case ($urandom_range(0, 7))
        0: len = $urandom_range(1, 33);
        1: len = $urandom_range(34, 41);
        default: len = $urandom_range(42, 60);
      endcase
      send_frame(len, 1'($urandom_range(0, 1)), pr, pick_addr(addrs[$urandom_range(0, 3)]),
                 $urandom, pick_addr(prts[$urandom_range(0, 3)]));
    end
  endtask

  initial begin
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 0; tbl_addr[i] = 0; tbl_sport[i] = 0;
      tbl_dport[i] = 0; tbl_proto[i] = 0; tbl_dir[i] = 0;
    end
    pos = 0; p_sa = 0; p_da = 0; p_ports = 0; p_proto = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_truncated();
    test_wildcards();
    test_random();
    go_idle();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (NRULES + 10) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("PASS wildcard_packet_rule_filter");
    end else begin
      $display("FAIL wildcard_packet_rule_filter");
    end
    $finish;
  end

endmodule
